FILE: rtl/ppc_pkg.sv
// Package for the polygon plane clipper.
// Holds the vertex and result types and the state machine encodings.
// Used by ppc_interp and the top level; depends on nothing.
package ppc_pkg;

    localparam int ATTR_W = 32;
    localparam int NUM_ATTR = 6;
    localparam int MIN_VERTS = 3;

    typedef struct packed {
        logic [NUM_ATTR-1:0][ATTR_W-1:0] attr;
        logic [ATTR_W-1:0]               plane_d;
    } vert_rec_t;

    typedef struct packed {
        logic                            overflow;
        logic                            empty_res;
        logic                            last_out;
        logic                            is_new;
        logic [NUM_ATTR-1:0][ATTR_W-1:0] attr;
    } result_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RDPRE,
        S_GETPRE,
        S_RDCUR,
        S_GETCUR,
        S_EMITPRE,
        S_CROSS,
        S_ISTART,
        S_IWAIT,
        S_PUSHNEW,
        S_NEXT,
        S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        IP_IDLE,
        IP_MUL_LO,
        IP_MUL_HI,
        IP_DIV,
        IP_DONE
    } ip_state_t;

endpackage

FILE: rtl/ppc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ppc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ppc_interp.sv
// Sequential interpolation unit: p + trunc((c - p) * pd / (pd - cd)).
// Split multiply over IP_MUL_LO and IP_MUL_HI, then a one-bit-per-cycle restoring divide.
// Depends on ppc_pkg.
module ppc_interp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] p,
    input  logic [31:0] c,
    input  logic [31:0] pd,
    input  logic [31:0] cd,
    output logic        done,
    output logic [31:0] result
);

    localparam int QW = 34;

    ppc_pkg::ip_state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [32:0] diff_mag_reg;
    logic [31:0] pd_mag_reg;
    logic [32:0] den_mag_reg;
    logic        neg_reg;
    logic [31:0] p_reg;
    logic [64:0] prod_reg;
    logic [32:0] rem_reg;
    logic [QW-1:0] quo_reg;

    logic [32:0] diff;
    logic [32:0] den;
    logic [64:0] sum_hi;
    logic [33:0] trial;
    logic        ge;
    logic [31:0] q_abs;

    assign diff   = {c[31], c} - {p[31], p};
    assign den    = {pd[31], pd} - {cd[31], cd};
    assign sum_hi = prod_reg + {49'(diff_mag_reg) * 49'(pd_mag_reg[31:16]), 16'b0};
    assign trial  = {rem_reg, prod_reg[QW-1]};
    assign ge     = trial >= {1'b0, den_mag_reg};
    assign q_abs  = quo_reg[31:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ppc_pkg::IP_IDLE:   if (start) state_next = ppc_pkg::IP_MUL_LO;
            ppc_pkg::IP_MUL_LO: state_next = ppc_pkg::IP_MUL_HI;
            ppc_pkg::IP_MUL_HI: state_next = ppc_pkg::IP_DIV;
            ppc_pkg::IP_DIV:    if (cnt_reg == 6'(QW - 1)) state_next = ppc_pkg::IP_DONE;
            ppc_pkg::IP_DONE:   state_next = ppc_pkg::IP_IDLE;
            default:            state_next = ppc_pkg::IP_IDLE;
        endcase
    end

    always_comb begin
        done   = (state_reg == ppc_pkg::IP_DONE);
        result = p_reg + (neg_reg ? (32'd0 - q_abs) : q_abs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppc_pkg::IP_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            ppc_pkg::IP_IDLE: begin
                diff_mag_reg <= diff[32] ? (33'd0 - diff) : diff;
                pd_mag_reg   <= pd[31] ? (32'd0 - pd) : pd;
                den_mag_reg  <= den[32] ? (33'd0 - den) : den;
                neg_reg      <= diff[32] ^ pd[31] ^ den[32];
                p_reg        <= p;
            end
            ppc_pkg::IP_MUL_LO: begin
                prod_reg <= {16'b0, 49'(diff_mag_reg) * 49'(pd_mag_reg[15:0])};
            end
            ppc_pkg::IP_MUL_HI: begin
                prod_reg <= sum_hi;
                rem_reg  <= {2'b0, sum_hi[64:QW]};
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            ppc_pkg::IP_DIV: begin
                rem_reg  <= ge ? 33'(trial - {1'b0, den_mag_reg}) : trial[32:0];
                quo_reg  <= {quo_reg[QW-2:0], ge};
                prod_reg <= {prod_reg[63:0], 1'b0};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/polygon_plane_clipper.sv
// Polygon clipper against one plane: loads vertices, then walks the edges.
// Top level; depends on ppc_pkg, ppc_ram and ppc_interp.
//
// Each vertex word taken is written to the vertex memory while there is room.
// The word with tlast closes the polygon; the block then stops taking words,
// fetches the closing vertex in RDPRE and GETPRE and walks each edge through
// RDCUR, GETCUR, EMITPRE, CROSS and NEXT. A crossing edge runs its six
// attributes through the shared multiply and bit-serial divide unit, then
// hands the new vertex on in PUSHNEW. Results are held one deep so that the
// final one can be marked with tlast; a polygon with fewer than three
// vertices or with nothing inside gives one empty result.
module polygon_plane_clipper #(
    parameter int MAX_VERTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // plane_dist, pos_x, pos_y, pos_z, tex_u, tex_v, light
    input  logic [223:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_u, out_v, out_light
    output logic [191:0] m_tdata,
    output logic         m_tlast,
    // is_new, empty_res, overflow
    output logic [2:0]   m_tuser
);

    localparam int AW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int VW = $bits(ppc_pkg::vert_rec_t);

    ppc_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg;
    logic             dropped_reg;
    logic [AW-1:0]    edge_reg;
    logic [2:0]       idx_reg;
    ppc_pkg::vert_rec_t pre_reg, cur_reg;
    logic [ppc_pkg::NUM_ATTR-1:0][31:0] new_reg;
    ppc_pkg::result_t hold_reg, out_reg;
    logic             hold_valid_reg, out_valid_reg;

    logic             accept, room, closing_small;
    logic [CW-1:0]    n_after;
    logic [AW-1:0]    raddr;
    logic [VW-1:0]    rdata;
    ppc_pkg::vert_rec_t rd_vertex;
    logic             out_free, push_ok, push_req, start, ip_done;
    ppc_pkg::result_t push_data, final_word;
    logic [31:0]      ip_result;
    logic             crosses, last_edge;

    assign accept        = s_tvalid && s_tready;
    assign room          = count_reg < CW'(MAX_VERTS);
    assign n_after       = room ? count_reg + CW'(1) : count_reg;
    assign closing_small = n_after < CW'(ppc_pkg::MIN_VERTS);
    assign rd_vertex     = ppc_pkg::vert_rec_t'(rdata);
    assign out_free      = !out_valid_reg || m_tready;
    assign push_ok       = !hold_valid_reg || out_free;
    assign crosses       = pre_reg.plane_d[31] != cur_reg.plane_d[31];
    assign last_edge     = CW'(edge_reg) == (count_reg - CW'(1));

    ppc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_ram (
        .aclk  (aclk),
        .we    (accept && room),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ppc_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .p       (pre_reg.attr[idx_reg]),
        .c       (cur_reg.attr[idx_reg]),
        .pd      (pre_reg.plane_d),
        .cd      (cur_reg.plane_d),
        .done    (ip_done),
        .result  (ip_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ppc_pkg::S_LOAD: begin
                if (accept && s_tlast) begin
                    state_next = closing_small ? ppc_pkg::S_FINAL : ppc_pkg::S_RDPRE;
                end
            end
            ppc_pkg::S_RDPRE:  state_next = ppc_pkg::S_GETPRE;
            ppc_pkg::S_GETPRE: state_next = ppc_pkg::S_RDCUR;
            ppc_pkg::S_RDCUR:  state_next = ppc_pkg::S_GETCUR;
            ppc_pkg::S_GETCUR: state_next = ppc_pkg::S_EMITPRE;
            ppc_pkg::S_EMITPRE: begin
                if (pre_reg.plane_d[31] || push_ok) state_next = ppc_pkg::S_CROSS;
            end
            ppc_pkg::S_CROSS:  state_next = crosses ? ppc_pkg::S_ISTART : ppc_pkg::S_NEXT;
            ppc_pkg::S_ISTART: state_next = ppc_pkg::S_IWAIT;
            ppc_pkg::S_IWAIT: begin
                if (ip_done) begin
                    state_next = (idx_reg == 3'(ppc_pkg::NUM_ATTR - 1)) ?
                                 ppc_pkg::S_PUSHNEW : ppc_pkg::S_ISTART;
                end
            end
            ppc_pkg::S_PUSHNEW: if (push_ok) state_next = ppc_pkg::S_NEXT;
            ppc_pkg::S_NEXT:   state_next = last_edge ? ppc_pkg::S_FINAL : ppc_pkg::S_RDCUR;
            ppc_pkg::S_FINAL:  if (out_free) state_next = ppc_pkg::S_LOAD;
            default:           state_next = ppc_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ppc_pkg::S_LOAD);
        start     = (state_reg == ppc_pkg::S_ISTART);
        raddr     = (state_reg == ppc_pkg::S_RDPRE) ? AW'(count_reg - CW'(1)) : edge_reg;
        push_req  = 1'b0;
        push_data = '0;
        push_data.overflow = dropped_reg;
        case (state_reg)
            ppc_pkg::S_EMITPRE: begin
                push_req       = !pre_reg.plane_d[31];
                push_data.attr = pre_reg.attr;
            end
            ppc_pkg::S_PUSHNEW: begin
                push_req         = 1'b1;
                push_data.attr   = new_reg;
                push_data.is_new = 1'b1;
            end
            default: begin
            end
        endcase
        final_word          = hold_reg;
        final_word.last_out = 1'b1;
        if (!hold_valid_reg) begin
            final_word           = '0;
            final_word.empty_res = 1'b1;
            final_word.last_out  = 1'b1;
            final_word.overflow  = dropped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ppc_pkg::S_LOAD;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((push_req && push_ok && hold_valid_reg) ||
                (state_reg == ppc_pkg::S_FINAL && out_free)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (room) begin
                    count_reg <= count_reg + CW'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (push_req && push_ok) begin
                hold_valid_reg <= 1'b1;
            end
            if (state_reg == ppc_pkg::S_FINAL && out_free) begin
                hold_valid_reg <= 1'b0;
                count_reg      <= '0;
                dropped_reg    <= 1'b0;
            end
        end

        if (push_req && push_ok) begin
            hold_reg <= push_data;
            if (hold_valid_reg) begin
                out_reg <= hold_reg;
            end
        end
        if (state_reg == ppc_pkg::S_FINAL && out_free) begin
            out_reg <= final_word;
        end
        case (state_reg)
            ppc_pkg::S_GETPRE: begin
                pre_reg  <= rd_vertex;
                edge_reg <= '0;
            end
            ppc_pkg::S_GETCUR: cur_reg <= rd_vertex;
            ppc_pkg::S_CROSS:  idx_reg <= '0;
            ppc_pkg::S_IWAIT: begin
                if (ip_done) begin
                    new_reg[idx_reg] <= ip_result;
                    idx_reg          <= idx_reg + 3'd1;
                end
            end
            ppc_pkg::S_NEXT: begin
                pre_reg  <= cur_reg;
                edge_reg <= edge_reg + AW'(1);
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.attr;
    assign m_tlast  = out_reg.last_out;
    assign m_tuser  = {out_reg.overflow, out_reg.empty_res, out_reg.is_new};

endmodule

FILE: rtl/ppc_checker.sv
// Port-level checks for the polygon plane clipper, bound to the top level.
// Depends on polygon_plane_clipper.
module ppc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         m_tlast,
    input logic [2:0]   m_tuser
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result word changed while stalled.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata == '0)
        else $error("Empty result is not a clean final word.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("Input taken right after closing a polygon.");

endmodule

bind polygon_plane_clipper ppc_checker u_ppc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
